// ===== rtl/core/udpf_pkg.sv =====
// shared constants, codes and types of the udp over ipv4 frame filter
`default_nettype none

package udpf_pkg;

   // frame bound and widths
   localparam int MAX_FRAME_BYTES = 16383;
   localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);
   localparam int ULEN_W          = 16;
   localparam int LEN_W           = (COUNT_W > ULEN_W) ? COUNT_W : ULEN_W;
   localparam int ADDR_W          = 32;
   localparam int OFFSET_W        = 7;
   localparam int PAYLOAD_LEN_W   = 14;

   // header geometry
   localparam int ETH_HDR_LEN     = 14;
   localparam int IP_MIN_HDR_LEN  = 20;
   localparam int UDP_HDR_LEN     = 8;
   localparam int UDP_LEN_REL     = 4;
   localparam int ULEN_POS_BASE   = ETH_HDR_LEN + UDP_LEN_REL;

   // byte positions of the fixed header fields
   localparam int POS_TYPE_HI     = 12;
   localparam int POS_TYPE_LO     = 13;
   localparam int POS_VER_IHL     = 14;
   localparam int POS_PROTO       = 23;
   localparam int POS_SRC_FIRST   = 26;
   localparam int POS_SRC_LAST    = 29;
   localparam int POS_DST_FIRST   = 30;
   localparam int POS_DST_LAST    = 33;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [3:0]  IP_VERSION4    = 4'd4;

   // frame queue, depth a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      VERDICT_OK            = 4'd0,
      VERDICT_SHORT         = 4'd1,
      VERDICT_NOT_IPV4      = 4'd2,
      VERDICT_BAD_HDR       = 4'd3,
      VERDICT_IP_TRUNC      = 4'd4,
      VERDICT_FILTER_MISS   = 4'd5,
      VERDICT_NOT_UDP       = 4'd6,
      VERDICT_UDP_TRUNC     = 4'd7,
      VERDICT_UDP_LEN_SMALL = 4'd8
   } verdict_type;

   typedef enum logic [1:0] {
      CSR_FILTER_ENABLE = 2'd0,
      CSR_SNAPSHOT_ADDR = 2'd1,
      CSR_UPDATE_ADDR   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              filter_enable;
      logic [ADDR_W-1:0] snapshot_addr;
      logic [ADDR_W-1:0] update_addr;
   } cfg_type;

   // everything the back end needs to judge one frame
   typedef struct packed {
      logic [COUNT_W-1:0] cap_len;
      logic [15:0]        ether_kind;
      logic [7:0]         version_ihl;
      logic [7:0]         proto_byte;
      logic [ADDR_W-1:0]  src_addr;
      logic [ADDR_W-1:0]  dst_addr;
      logic [ULEN_W-1:0]  udp_len;
   } frame_snap_type;

endpackage

`default_nettype wire

// ===== rtl/core/udpf_req_if.sv =====
// frame byte channel
`default_nettype none

interface udpf_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/udpf_rsp_if.sv =====
// verdict channel
`default_nettype none

interface udpf_rsp_if import udpf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   verdict_type              verdict_code;
   logic [ADDR_W-1:0]        source_addr;
   logic [ADDR_W-1:0]        dest_addr;
   logic [OFFSET_W-1:0]      payload_offset;
   logic [PAYLOAD_LEN_W-1:0] payload_length;

   modport source (output valid, output accepted, output verdict_code,
                   output source_addr, output dest_addr, output payload_offset,
                   output payload_length, input ready);
   modport sink   (input valid, input accepted, input verdict_code,
                   input source_addr, input dest_addr, input payload_offset,
                   input payload_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/udpf_csr_if.sv =====
// configuration write channel
`default_nettype none

interface udpf_csr_if import udpf_pkg::*; ();
   logic              valid;
   logic              ready;
   csr_index_type     reg_index;
   logic [ADDR_W-1:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/udpf_front.sv =====
// front end: byte counter and header field capture, one frame snapshot per last byte
`default_nettype none

module udpf_front import udpf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   udpf_req_if.sink       req,
   input  logic           queue_full,
   output logic           push,
   output frame_snap_type push_entry
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        ether_ff, ether_in, ether_upd;
   logic [7:0]         vihl_ff, vihl_in, vihl_upd;
   logic [7:0]         proto_ff, proto_in, proto_upd;
   logic [ADDR_W-1:0]  src_ff, src_in, src_upd;
   logic [ADDR_W-1:0]  dst_ff, dst_in, dst_upd;
   logic [ULEN_W-1:0]  ulen_ff, ulen_in, ulen_upd;
   logic               accept;
   logic [5:0]         hdr_len;
   logic [6:0]         ulen_pos;
   logic [6:0]         ulen_pos_lo;
   logic [COUNT_W-1:0] cap_len;

   assign req.ready = !queue_full;

   always_comb begin
      accept      = req.valid && req.ready;
      hdr_len     = {vihl_ff[3:0], 2'b00};
      // udp length sits 4 bytes into the udp header; always past the ihl byte
      ulen_pos    = 7'(ULEN_POS_BASE) + {1'b0, hdr_len};
      ulen_pos_lo = ulen_pos + 7'd1;
      // saturating count doubles as the captured length so far
      cap_len     = (count_ff == COUNT_W'(MAX_FRAME_BYTES)) ? count_ff
                                                            : count_ff + COUNT_W'(1);

      ether_upd = ether_ff;
      vihl_upd  = vihl_ff;
      proto_upd = proto_ff;
      src_upd   = src_ff;
      dst_upd   = dst_ff;
      ulen_upd  = ulen_ff;
      if (count_ff == COUNT_W'(POS_TYPE_HI) || count_ff == COUNT_W'(POS_TYPE_LO)) begin
         ether_upd = {ether_ff[7:0], req.data_byte};
      end
      if (count_ff == COUNT_W'(POS_VER_IHL)) begin
         vihl_upd = req.data_byte;
      end
      if (count_ff == COUNT_W'(POS_PROTO)) begin
         proto_upd = req.data_byte;
      end
      if (count_ff >= COUNT_W'(POS_SRC_FIRST) && count_ff <= COUNT_W'(POS_SRC_LAST)) begin
         src_upd = {src_ff[ADDR_W-9:0], req.data_byte};
      end
      if (count_ff >= COUNT_W'(POS_DST_FIRST) && count_ff <= COUNT_W'(POS_DST_LAST)) begin
         dst_upd = {dst_ff[ADDR_W-9:0], req.data_byte};
      end
      if (count_ff == COUNT_W'(ulen_pos) || count_ff == COUNT_W'(ulen_pos_lo)) begin
         ulen_upd = {ulen_ff[7:0], req.data_byte};
      end

      push       = accept && req.is_last;
      push_entry = '{cap_len: cap_len, ether_kind: ether_upd, version_ihl: vihl_upd,
                     proto_byte: proto_upd, src_addr: src_upd, dst_addr: dst_upd,
                     udp_len: ulen_upd};

      count_in = count_ff;
      ether_in = ether_ff;
      vihl_in  = vihl_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      ulen_in  = ulen_ff;
      if (push) begin
         count_in = '0;
         ether_in = '0;
         vihl_in  = '0;
         proto_in = '0;
         src_in   = '0;
         dst_in   = '0;
         ulen_in  = '0;
      end else if (accept) begin
         count_in = cap_len;
         ether_in = ether_upd;
         vihl_in  = vihl_upd;
         proto_in = proto_upd;
         src_in   = src_upd;
         dst_in   = dst_upd;
         ulen_in  = ulen_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ether_ff <= '0;
         vihl_ff  <= '0;
         proto_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         ulen_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ether_ff <= ether_in;
         vihl_ff  <= vihl_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         ulen_ff  <= ulen_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_FRAME_BYTES))
      else $error("byte count past frame bound");
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      push |=> (count_ff == '0))
      else $error("byte count not cleared after last beat");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("snapshot pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/udpf_queue.sv =====
// short frame snapshot queue between front and back end
`default_nettype none

module udpf_queue import udpf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_snap_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output frame_snap_type head_entry
);

   frame_snap_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      full       = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
      head_valid = (cnt_ff != '0);
      head_entry = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      cnt_in     = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill above depth");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      QUEUE_PTR_W'(wr_ptr_ff - rd_ptr_ff) == QUEUE_PTR_W'(cnt_ff))
      else $error("queue pointers disagree with fill");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/udpf_back.sv =====
// back end: verdict checks on one frame snapshot and the result register
`default_nettype none

module udpf_back import udpf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           head_valid,
   input  frame_snap_type head,
   output logic           pop,
   udpf_rsp_if.source     rsp
);

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     accepted_ff;
   verdict_type              verdict_ff;
   logic [ADDR_W-1:0]        src_ff, dst_ff;
   logic [OFFSET_W-1:0]      offset_ff;
   logic [PAYLOAD_LEN_W-1:0] plen_ff;

   logic               load;
   logic [5:0]         hdr_len;
   logic [COUNT_W-1:0] hdr_end;
   logic [COUNT_W-1:0] pay_off;
   logic [ULEN_W-1:0]  declared;
   logic [COUNT_W-1:0] avail;
   logic [LEN_W-1:0]   min_len;
   logic               addr_hit;
   verdict_type        verdict;
   logic               addr_known;

   always_comb begin
      hdr_len  = {head.version_ihl[3:0], 2'b00};
      hdr_end  = COUNT_W'(ETH_HDR_LEN) + COUNT_W'(hdr_len);
      pay_off  = hdr_end + COUNT_W'(UDP_HDR_LEN);
      declared = head.udp_len - ULEN_W'(UDP_HDR_LEN);
      avail    = head.cap_len - pay_off;
      min_len  = (LEN_W'(declared) < LEN_W'(avail)) ? LEN_W'(declared) : LEN_W'(avail);
      addr_hit = (head.src_addr == cfg.snapshot_addr) || (head.src_addr == cfg.update_addr) ||
                 (head.dst_addr == cfg.snapshot_addr) || (head.dst_addr == cfg.update_addr);

      // first failing check wins
      if (head.cap_len < COUNT_W'(ETH_HDR_LEN + IP_MIN_HDR_LEN)) begin
         verdict = VERDICT_SHORT;
      end else if (head.ether_kind != ETHERTYPE_IPV4) begin
         verdict = VERDICT_NOT_IPV4;
      end else if (head.version_ihl[7:4] != IP_VERSION4 ||
                   hdr_len < 6'(IP_MIN_HDR_LEN)) begin
         verdict = VERDICT_BAD_HDR;
      end else if (hdr_end > head.cap_len) begin
         verdict = VERDICT_IP_TRUNC;
      end else if (cfg.filter_enable && !addr_hit) begin
         verdict = VERDICT_FILTER_MISS;
      end else if (head.proto_byte != PROTO_UDP) begin
         verdict = VERDICT_NOT_UDP;
      end else if (pay_off > head.cap_len) begin
         verdict = VERDICT_UDP_TRUNC;
      end else if (head.udp_len < ULEN_W'(UDP_HDR_LEN)) begin
         verdict = VERDICT_UDP_LEN_SMALL;
      end else begin
         verdict = VERDICT_OK;
      end

      // addresses are only reported once the ip header was complete
      addr_known = !(verdict inside {VERDICT_SHORT, VERDICT_NOT_IPV4,
                                     VERDICT_BAD_HDR, VERDICT_IP_TRUNC});

      load         = !rsp_valid_ff || rsp.ready;
      pop          = head_valid && load;
      rsp_valid_in = load ? head_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         accepted_ff <= (verdict == VERDICT_OK);
         verdict_ff  <= verdict;
         src_ff      <= addr_known ? head.src_addr : '0;
         dst_ff      <= addr_known ? head.dst_addr : '0;
         offset_ff   <= (verdict == VERDICT_OK) ? OFFSET_W'(pay_off) : '0;
         plen_ff     <= (verdict == VERDICT_OK) ? PAYLOAD_LEN_W'(min_len) : '0;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.accepted       = accepted_ff;
   assign rsp.verdict_code   = verdict_ff;
   assign rsp.source_addr    = src_ff;
   assign rsp.dest_addr      = dst_ff;
   assign rsp.payload_offset = offset_ff;
   assign rsp.payload_length = plen_ff;

`ifndef NO_ASSERTIONS
   a_accept_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (accepted_ff == (verdict_ff == VERDICT_OK)))
      else $error("accepted flag disagrees with verdict");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !accepted_ff) |-> (offset_ff == '0 && plen_ff == '0))
      else $error("rejected frame carries payload span");
   a_addr_hidden: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (verdict_ff == VERDICT_SHORT || verdict_ff == VERDICT_NOT_IPV4 ||
                        verdict_ff == VERDICT_BAD_HDR || verdict_ff == VERDICT_IP_TRUNC))
      |-> (src_ff == '0 && dst_ff == '0))
      else $error("addresses shown before ip header complete");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/udp_ipv4_frame_filter.sv =====
// top level of the udp over ipv4 frame filter
`default_nettype none

// udp over ipv4 frame filter. frames enter on req_chan one byte per beat in
// wire order, with is_last set on the final captured byte; each last beat
// yields exactly one verdict beat on rsp_chan. the front end takes one byte
// every clock unless the queue is full, counting bytes (saturating at the
// frame bound) and grabbing ethertype, version/ihl, protocol, addresses and
// the udp length field as they fly by. on the last byte it pushes a snapshot
// of the frame into a four entry queue; the back end pops a snapshot, runs
// the checks in priority order and registers the result, so the verdict
// passes the queue slot and then the output register. req_chan only stalls
// when the queue holds four snapshots behind the verdict held in the output
// register by a stalled rsp_chan, so with rsp_chan ready the rate is one
// byte per clock for any frame length, down to one-byte frames. configuration
// writes on csr_chan are taken every cycle and should land only while no
// frame is in flight; there is no clearing pass after reset.

module udp_ipv4_frame_filter import udpf_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   udpf_req_if.sink      req_chan,
   udpf_rsp_if.source    rsp_chan,
   udpf_csr_if.sink      csr_chan
);

   cfg_type        cfg_ff, cfg_in;
   logic           push;
   frame_snap_type push_entry;
   logic           queue_full;
   logic           pop;
   logic           head_valid;
   frame_snap_type head_entry;

   // register writes always complete in one beat
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_FILTER_ENABLE: cfg_in.filter_enable = csr_chan.write_data[0];
            CSR_SNAPSHOT_ADDR: cfg_in.snapshot_addr = csr_chan.write_data;
            CSR_UPDATE_ADDR:   cfg_in.update_addr   = csr_chan.write_data;
            default:           cfg_in = cfg_ff;   // unmapped index is dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // byte capture and frame snapshot
   udpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples the byte stream from the verdict consumer
   udpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // checks and the output register
   udpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head_entry),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== sim/udp_ipv4_frame_filter_checker.sv =====
// verdict checker: watches all three channels, predicts each verdict beat and compares it
`timescale 1ns / 100ps

module udp_ipv4_frame_filter_checker import udpf_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   udpf_req_if        req_mon,
   udpf_rsp_if        rsp_mon,
   udpf_csr_if        csr_mon,
   output int         mismatches,
   output int         verdicts_pending,
   output int         verdicts_checked,
   output int         frames_accepted,
   output logic [8:0] codes_seen
);

   typedef struct packed {
      logic                     accepted;
      verdict_type              code;
      logic [ADDR_W-1:0]        src;
      logic [ADDR_W-1:0]        dst;
      logic [OFFSET_W-1:0]      offset;
      logic [PAYLOAD_LEN_W-1:0] length;
   } verdict_beat_type;

   verdict_beat_type expected_verdicts [$];

   // mirrored registers
   logic              match_enable;
   logic [ADDR_W-1:0] match_addr_a;
   logic [ADDR_W-1:0] match_addr_b;

   // header fields grabbed from the frame in flight
   logic [COUNT_W-1:0] bytes_seen;
   logic [15:0]        eth_type;
   logic [7:0]         ver_ihl;
   logic [7:0]         ip_proto;
   logic [ADDR_W-1:0]  src_acc;
   logic [ADDR_W-1:0]  dst_acc;
   logic [15:0]        udp_len;

   task automatic clear_frame();
      bytes_seen = '0;
      eth_type   = '0;
      ver_ihl    = '0;
      ip_proto   = '0;
      src_acc    = '0;
      dst_acc    = '0;
      udp_len    = '0;
   endtask

   function automatic verdict_type judge_frame(input int caplen, output int offset,
                                               output int length);
      int  hlen;
      int  declared;
      int  room;
      logic hit;
      hlen   = int'(ver_ihl[3:0]) * 4;
      offset = 0;
      length = 0;
      hit    = src_acc == match_addr_a || src_acc == match_addr_b ||
               dst_acc == match_addr_a || dst_acc == match_addr_b;
      if (caplen < ETH_HDR_LEN + IP_MIN_HDR_LEN) return VERDICT_SHORT;
      if (eth_type != ETHERTYPE_IPV4) return VERDICT_NOT_IPV4;
      if (ver_ihl[7:4] != IP_VERSION4 || hlen < IP_MIN_HDR_LEN) return VERDICT_BAD_HDR;
      if (ETH_HDR_LEN + hlen > caplen) return VERDICT_IP_TRUNC;
      if (match_enable && !hit) return VERDICT_FILTER_MISS;
      if (ip_proto != PROTO_UDP) return VERDICT_NOT_UDP;
      if (ETH_HDR_LEN + hlen + UDP_HDR_LEN > caplen) return VERDICT_UDP_TRUNC;
      if (int'(udp_len) < UDP_HDR_LEN) return VERDICT_UDP_LEN_SMALL;
      offset   = ETH_HDR_LEN + hlen + UDP_HDR_LEN;
      declared = int'(udp_len) - UDP_HDR_LEN;
      room     = caplen - offset;
      length   = (declared < room) ? declared : room;
      return VERDICT_OK;
   endfunction

   task automatic take_byte(input logic [7:0] value, input logic last);
      int               pos;
      int               len_pos;
      int               caplen;
      int               offset;
      int               length;
      logic             addr_known;
      verdict_type      code;
      verdict_beat_type beat;
      pos     = int'(bytes_seen);
      len_pos = ULEN_POS_BASE + int'(ver_ihl[3:0]) * 4;
      if (pos == POS_TYPE_HI || pos == POS_TYPE_LO) eth_type = {eth_type[7:0], value};
      if (pos == POS_VER_IHL) ver_ihl = value;
      if (pos == POS_PROTO) ip_proto = value;
      if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) src_acc = {src_acc[23:0], value};
      if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) dst_acc = {dst_acc[23:0], value};
      // udp length position follows the ihl seen so far
      if (pos > POS_VER_IHL && (pos == len_pos || pos == len_pos + 1))
         udp_len = {udp_len[7:0], value};
      caplen = (pos >= MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : pos + 1;
      if (pos < MAX_FRAME_BYTES) bytes_seen = bytes_seen + COUNT_W'(1);
      if (last) begin
         code        = judge_frame(caplen, offset, length);
         addr_known  = (code == VERDICT_OK) || (code >= VERDICT_FILTER_MISS);
         beat.accepted = (code == VERDICT_OK);
         beat.code   = code;
         beat.src    = addr_known ? src_acc : '0;
         beat.dst    = addr_known ? dst_acc : '0;
         beat.offset = offset[OFFSET_W-1:0];
         beat.length = length[PAYLOAD_LEN_W-1:0];
         expected_verdicts.push_back(beat);
         clear_frame();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%0t verdict %0d: %s got 0x%0h want 0x%0h",
               $time, verdicts_checked, what, got, want);
   endtask

   task automatic check_verdict();
      verdict_beat_type want;
      if (expected_verdicts.size() == 0) begin
         report_mismatch("verdict beat with no frame pending", rsp_mon.verdict_code, 0);
         return;
      end
      want = expected_verdicts.pop_front();
      if (rsp_mon.accepted !== want.accepted)
         report_mismatch("accepted", rsp_mon.accepted, want.accepted);
      if (rsp_mon.verdict_code !== want.code)
         report_mismatch("verdict_code", rsp_mon.verdict_code, want.code);
      if (rsp_mon.source_addr !== want.src)
         report_mismatch("source_addr", rsp_mon.source_addr, want.src);
      if (rsp_mon.dest_addr !== want.dst)
         report_mismatch("dest_addr", rsp_mon.dest_addr, want.dst);
      if (rsp_mon.payload_offset !== want.offset)
         report_mismatch("payload_offset", rsp_mon.payload_offset, want.offset);
      if (rsp_mon.payload_length !== want.length)
         report_mismatch("payload_length", rsp_mon.payload_length, want.length);
      verdicts_checked++;
      if (want.accepted) frames_accepted++;
      codes_seen[want.code] = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         match_enable = 1'b0;
         match_addr_a = '0;
         match_addr_b = '0;
         clear_frame();
         expected_verdicts.delete();
         verdicts_checked = 0;
         frames_accepted  = 0;
         codes_seen       = '0;
      end else begin
         // result side first: a verdict never belongs to a byte of the same edge
         if (rsp_mon.valid && rsp_mon.ready) check_verdict();
         if (req_mon.valid && req_mon.ready) take_byte(req_mon.data_byte, req_mon.is_last);
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.reg_index)
               CSR_FILTER_ENABLE: match_enable = csr_mon.write_data[0];
               CSR_SNAPSHOT_ADDR: match_addr_a = csr_mon.write_data;
               CSR_UPDATE_ADDR:   match_addr_b = csr_mon.write_data;
               default: ;
            endcase
         end
      end
      verdicts_pending <= expected_verdicts.size();
   end

endmodule

// ===== sim/udp_ipv4_frame_filter_tb.sv =====
// testbench top: clock, reset, frame stimulus, receiver stalls and the final verdict
`timescale 1ns / 100ps

module udp_ipv4_frame_filter_tb;
   import udpf_pkg::*;

   localparam int RANDOM_BYTES  = 100;      // random byte budget over all phases
   localparam int PHASES        = 5;
   localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
   localparam int HOLD_FRAMES   = 10;       // short frames offered during a hold-off
   localparam int DRAIN_CYCLES  = 8;        // margin after the last pending verdict is checked
   localparam int CYCLE_LIMIT   = 1_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   udpf_req_if req_bus ();
   udpf_rsp_if rsp_bus ();
   udpf_csr_if csr_bus ();

   int         mismatches;
   int         verdicts_pending;
   int         verdicts_checked;
   int         frames_accepted;
   logic [8:0] codes_seen;

   // sender bookkeeping
   int          cycle_count = 0;
   int          bytes_sent  = 0;
   int          frames_sent = 0;
   int          burst_left  = 0;
   int          holds_asked = 0;
   bit          gapless     = 1'b0;
   logic [7:0]  frame_buf [$];
   logic [31:0] cur_addr_a  = '0;
   logic [31:0] cur_addr_b  = '0;

   udp_ipv4_frame_filter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   udp_ipv4_frame_filter_checker verdict_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_mon          (csr_bus),
      .mismatches       (mismatches),
      .verdicts_pending (verdicts_pending),
      .verdicts_checked (verdicts_checked),
      .frames_accepted  (frames_accepted),
      .codes_seen       (codes_seen)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- channel helpers

   // offer one byte beat and hold it until the block takes it
   task automatic send_beat(input logic [7:0] value, input logic last);
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      req_bus.is_last   <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      bytes_sent++;
   endtask

   // sender gap; zero means keep streaming
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // stream frame_buf out in bursts, gaps land anywhere inside the frame
   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 64);
            if (!gapless) pause_sender($urandom_range(0, 10));
         end
         burst_left--;
         send_beat(frame_buf[i], i == frame_buf.size() - 1);
      end
      frames_sent++;
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= idx;
      csr_bus.write_data <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
   endtask

   // all three registers back to back, valid drops once after the last beat
   task automatic program_filter(input bit enable, input logic [31:0] addr_a,
                                 input logic [31:0] addr_b);
      csr_write(CSR_FILTER_ENABLE, {31'd0, enable});
      csr_write(CSR_SNAPSHOT_ADDR, addr_a);
      csr_write(CSR_UPDATE_ADDR, addr_b);
      csr_bus.valid <= 1'b0;
      cur_addr_a = addr_a;
      cur_addr_b = addr_b;
   endtask

   // stop sending, let every verdict come home, then let the pipe drain
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- frame builder

   // random filler with the header fields laid over it; cut > 0 truncates the capture
   task automatic build_frame(input logic [15:0] etype, input logic [7:0] vi,
                              input logic [7:0] proto, input logic [31:0] src,
                              input logic [31:0] dst, input logic [15:0] ulen,
                              input int payload, input int cut);
      int         hlen;
      int         total;
      int         upos;
      logic [7:0] b;
      hlen  = int'(vi[3:0]) * 4;
      total = ETH_HDR_LEN + ((hlen > IP_MIN_HDR_LEN) ? hlen : IP_MIN_HDR_LEN) +
              UDP_HDR_LEN + payload;
      if (cut > 0) total = cut;
      upos = ULEN_POS_BASE + hlen;
      frame_buf.delete();
      for (int p = 0; p < total; p++) begin
         b = 8'($urandom_range(0, 255));
         if (p == POS_TYPE_HI) b = etype[15:8];
         if (p == POS_TYPE_LO) b = etype[7:0];
         if (p == POS_VER_IHL) b = vi;
         if (p == POS_PROTO) b = proto;
         if (p >= POS_SRC_FIRST && p <= POS_SRC_LAST) b = src[8*(POS_SRC_LAST-p) +: 8];
         if (p >= POS_DST_FIRST && p <= POS_DST_LAST) b = dst[8*(POS_DST_LAST-p) +: 8];
         // udp length goes where the ihl puts it, even on top of ip fields
         if (p > POS_VER_IHL && p == upos) b = ulen[15:8];
         if (p > POS_VER_IHL && p == upos + 1) b = ulen[7:0];
         frame_buf.push_back(b);
      end
   endtask

   // half the time a configured address so the filter hits often, otherwise anything
   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 3))
         0:       return cur_addr_a;
         1:       return cur_addr_b;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------- directed frames

   task automatic directed_frames();
      logic [31:0] a;
      logic [31:0] b;
      a = 32'hC0A8_0001;
      b = 32'h0A00_00FE;
      // one-byte frames at both byte extremes
      frame_buf = {8'hFF};
      send_frame();
      frame_buf = {8'h00};
      send_frame();
      // one byte shy of the fixed headers
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, a, b, 16'd8, 0, 33);
      send_frame();
      // ip header complete, udp header missing
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, a, b, 16'd8, 0, 34);
      send_frame();
      // wrong ethertype
      build_frame(16'h86DD, 8'h45, PROTO_UDP, a, b, 16'd8, 0, 0);
      send_frame();
      // wrong version
      build_frame(ETHERTYPE_IPV4, 8'h65, PROTO_UDP, a, b, 16'd8, 0, 0);
      send_frame();
      // ihl below five, udp length sits inside the ip header
      build_frame(ETHERTYPE_IPV4, 8'h43, PROTO_UDP, a, b, 16'h0010, 4, 0);
      send_frame();
      // longest ip header, cut short inside it
      build_frame(ETHERTYPE_IPV4, 8'h4F, PROTO_UDP, a, b, 16'd20, 12, 50);
      send_frame();
      // longest ip header, whole frame
      build_frame(ETHERTYPE_IPV4, 8'h4F, PROTO_UDP, a, b, 16'd20, 12, 0);
      send_frame();
      // not udp
      build_frame(ETHERTYPE_IPV4, 8'h45, 8'd6, a, b, 16'd8, 0, 0);
      send_frame();
      // udp length below its header, then exactly the header
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, a, b, 16'd7, 0, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, a, b, 16'd8, 0, 0);
      send_frame();
      // declared payload longer than captured, then shorter
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, a, b, 16'd40, 5, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, a, b, 16'd10, 20, 0);
      send_frame();
      // address and length extremes
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 3, 0);
      send_frame();
   endtask

   // filter on: hits on each address in each slot, misses, and miss ahead of protocol
   task automatic filter_frames(input logic [31:0] a, input logic [31:0] b);
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, a, 32'h0102_0304, 16'd12, 4, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 32'h0102_0304, b, 16'd12, 4, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, b, 32'h0506_0708, 16'd9, 1, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 32'h0506_0708, a, 16'd9, 1, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 32'h0102_0304, 32'h0506_0708,
                  16'd9, 1, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 8'h45, 8'd1, 32'h0102_0304, 32'h0506_0708, 16'd8, 0, 0);
      send_frame();
   endtask

   // ---------------------------------------------------------------- random frames

   // mostly well-formed udp with random content, the rest broken one way or another
   task automatic random_frame();
      int          kind;
      int          ihl;
      int          payload;
      int          declared;
      int          cut;
      logic [15:0] etype;
      logic [15:0] ulen;
      logic [7:0]  vi;
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
      kind     = $urandom_range(0, 99);
      ihl      = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
      payload  = $urandom_range(0, 12);
      declared = payload + $urandom_range(0, 6) - 3;
      if (declared < 0) declared = 0;
      etype = ETHERTYPE_IPV4;
      vi    = {IP_VERSION4, 4'(ihl)};
      proto = PROTO_UDP;
      ulen  = 16'(declared + UDP_HDR_LEN);
      src   = pick_addr();
      dst   = pick_addr();
      cut   = 0;
      if ($urandom_range(0, 9) == 0) ulen = 16'($urandom);
      if (kind >= 60 && kind < 68) begin
         etype = 16'($urandom);
      end else if (kind >= 68 && kind < 74) begin
         if ($urandom_range(0, 1) == 0) vi = {4'($urandom), 4'(ihl)};
         else vi = {IP_VERSION4, 4'($urandom_range(0, 4))};
      end else if (kind >= 74 && kind < 80) begin
         proto = 8'($urandom);
      end else if (kind >= 80 && kind < 86) begin
         ulen = 16'($urandom_range(0, 7));
      end else if (kind >= 86 && kind < 94) begin
         cut = $urandom_range(1, ETH_HDR_LEN + ihl * 4 + UDP_HDR_LEN + payload);
      end
      if (kind >= 94) begin
         // plain noise of any short length
         frame_buf.delete();
         repeat ($urandom_range(1, 60)) frame_buf.push_back(8'($urandom));
      end else begin
         build_frame(etype, vi, proto, src, dst, ulen, payload, cut);
      end
      send_frame();
   endtask

   // a run of tiny noise frames, each one a verdict, to fill the queue quickly
   task automatic short_frames(input int count);
      repeat (count) begin
         frame_buf.delete();
         repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom));
         send_frame();
      end
   endtask

   // ---------------------------------------------------------------- receiver

   // rsp ready follows a changing pattern; a requested hold-off keeps it low for a long
   // stretch so the frame queue fills and the byte channel backs up
   initial begin : receiver
      int mode;
      int mode_left;
      int holds_done;
      int tick;
      mode       = 0;
      mode_left  = 0;
      holds_done = 0;
      tick       = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (holds_done < holds_asked) begin
            rsp_bus.ready <= 1'b0;
            holds_done++;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;                        // no stalls
               1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0); // light stalls
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0); // heavy stalls
               default: rsp_bus.ready <= (tick % 4 != 3);             // periodic
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d verdicts still pending",
               cycle_count, verdicts_pending);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int          phase_bytes;
      logic [31:0] addr_a;
      logic [31:0] addr_b;
      addr_a = 32'hC0A8_0001;
      addr_b = 32'h0A00_00FE;
      // every block input known from time zero
      req_bus.valid      <= 1'b0;
      req_bus.data_byte  <= '0;
      req_bus.is_last    <= 1'b0;
      csr_bus.valid      <= 1'b0;
      csr_bus.reg_index  <= CSR_FILTER_ENABLE;
      csr_bus.write_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // filter off: header checks and length corner cases
      program_filter(1'b0, 32'h0, 32'h0);
      directed_frames();
      settle();

      // filter on with two distinct addresses
      program_filter(1'b1, addr_a, addr_b);
      filter_frames(addr_a, addr_b);

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            0:       program_filter(1'b1, addr_a, addr_b);
            1:       program_filter(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2:       program_filter(1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
            3:       program_filter(1'b1, $urandom, $urandom);
            default: program_filter(1'b0, 32'h0, 32'h0);
         endcase
         // back-to-back frames against a long receiver hold-off
         if (ph == 0 || ph == 3) begin
            holds_asked++;
            gapless = 1'b1;
            short_frames(HOLD_FRAMES);
         end
         phase_bytes = bytes_sent;
         while (bytes_sent - phase_bytes < RANDOM_BYTES / PHASES) begin
            gapless = ($urandom_range(0, 3) == 0);
            random_frame();
         end
      end
      settle();

      $display("run covered %0d bytes in %0d frames over %0d cycles, %0d register settings",
               bytes_sent, frames_sent, cycle_count, PHASES + 2);
      $display("%0d verdicts checked, %0d accepted, verdict codes seen 8..0: %b",
               verdicts_checked, frames_accepted, codes_seen);
      if (mismatches == 0 && verdicts_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/udpf_pkg.sv
rtl/core/udpf_req_if.sv
rtl/core/udpf_rsp_if.sv
rtl/core/udpf_csr_if.sv
rtl/core/udpf_front.sv
rtl/core/udpf_queue.sv
rtl/core/udpf_back.sv
rtl/core/udp_ipv4_frame_filter.sv
sim/udp_ipv4_frame_filter_checker.sv
sim/udp_ipv4_frame_filter_tb.sv
